// File: hw/rtl/mavg_pkg.sv
// Shared types and constants for the moving average filter.
package mavg_pkg;

  localparam int MAX_WINDOW     = 32;
  localparam int SAMPLE_W       = 16;
  localparam int CFG_W          = $clog2(MAX_WINDOW + 1);
  localparam int HELD_W         = $clog2(MAX_WINDOW + 1);
  localparam int DEFAULT_WINDOW = 8;

  typedef enum logic {
    ACT_PUSH  = 1'b0,
    ACT_CLEAR = 1'b1
  } action_t;

  typedef struct packed {
    action_t                     action;
    logic signed [SAMPLE_W-1:0]  sample;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  average;
    logic [HELD_W-1:0]           samples_held;
  } result_t;

  typedef enum logic {
    FS_IDLE,
    FS_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_RUN,
    DS_DONE
  } div_state_t;

endpackage

// File: hw/rtl/mavg_front.sv
// Front end: takes beats, keeps the history ring and running sum, issues sum/count jobs.
module mavg_front #(
  parameter int SW         = $clog2(mavg_pkg::MAX_WINDOW),
  parameter int CW         = $clog2(mavg_pkg::MAX_WINDOW + 1),
  parameter int SUM_W      = mavg_pkg::SAMPLE_W + $clog2(mavg_pkg::MAX_WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [mavg_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  mavg_pkg::item_t               item,
  output logic                          job_valid,
  input  logic                          job_ready,
  output logic signed [SUM_W-1:0]       job_sum,
  output logic [CW-1:0]                 job_held
);
  import mavg_pkg::*;

  localparam int DEF_WIN = (DEFAULT_WINDOW <= MAX_WINDOW) ? DEFAULT_WINDOW : MAX_WINDOW;

  logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];

  front_state_t               state, state_next;
  logic [CW-1:0]              window_len, window_len_next;
  logic [CW-1:0]              fill, fill_next;
  logic [SW-1:0]              wslot, wslot_next;
  logic signed [SUM_W-1:0]    run_sum, run_sum_next;
  logic [SW-1:0]              cur_slot, cur_slot_next;
  logic signed [SAMPLE_W-1:0] cur_sample, cur_sample_next;
  logic                       cur_full, cur_full_next;
  logic signed [SAMPLE_W-1:0] rd_data;

  logic                       rd_en, wr_en;
  logic [SW-1:0]              adj_slot;
  logic [CW-1:0]              slot_inc;
  logic                       cfg_bad;

  assign cfg_bad  = (cfg_wdata == '0) || (32'(cfg_wdata) > MAX_WINDOW);
  assign adj_slot = (CW'(wslot) >= window_len) ? '0 : wslot;
  assign slot_inc = CW'(cur_slot) + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FS_IDLE;
      window_len <= CW'(DEF_WIN);
      fill       <= '0;
      wslot      <= '0;
      run_sum    <= '0;
    end else begin
      state      <= state_next;
      window_len <= window_len_next;
      fill       <= fill_next;
      wslot      <= wslot_next;
      run_sum    <= run_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_slot   <= cur_slot_next;
    cur_sample <= cur_sample_next;
    cur_full   <= cur_full_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[cur_slot] <= cur_sample;
    end
    if (rd_en) begin
      rd_data <= hist[adj_slot];
    end
  end

  always_comb begin
    state_next      = state;
    window_len_next = window_len;
    fill_next       = fill;
    wslot_next      = wslot;
    run_sum_next    = run_sum;
    cur_slot_next   = cur_slot;
    cur_sample_next = cur_sample;
    cur_full_next   = cur_full;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    item_ready      = 1'b0;
    job_valid       = 1'b0;
    job_sum         = run_sum + SUM_W'(cur_sample)
                      - (cur_full ? SUM_W'(rd_data) : SUM_W'(0));
    job_held        = cur_full ? fill : fill + CW'(1);
    case (state)
      FS_IDLE: begin
        item_ready = !cfg_wen;
        if (cfg_wen) begin
          window_len_next = cfg_bad ? CW'(DEF_WIN) : CW'(cfg_wdata);
          fill_next       = '0;
          wslot_next      = '0;
          run_sum_next    = '0;
        end else if (item_valid) begin
          if (item.action == ACT_CLEAR) begin
            fill_next    = '0;
            wslot_next   = '0;
            run_sum_next = '0;
          end else begin
            rd_en           = 1'b1;
            cur_slot_next   = adj_slot;
            cur_sample_next = item.sample;
            cur_full_next   = (fill >= window_len);
            state_next      = FS_UPDATE;
          end
        end
      end
      FS_UPDATE: begin
        job_valid = 1'b1;
        if (job_ready) begin
          wr_en        = 1'b1;
          run_sum_next = job_sum;
          fill_next    = job_held;
          wslot_next   = (slot_inc >= window_len) ? '0 : SW'(slot_inc);
          state_next   = FS_IDLE;
        end
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/mavg_queue.sv
// Two-entry job queue between the front end and the divider.
module mavg_queue #(
  parameter int W = 27
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] slots [2];
  logic         wp, rp;
  logic [1:0]   count;
  logic         push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/mavg_divider.sv
// Back end: serial signed divide of sum by count, one quotient bit per cycle, result register.
module mavg_divider #(
  parameter int CW         = $clog2(mavg_pkg::MAX_WINDOW + 1),
  parameter int SUM_W      = mavg_pkg::SAMPLE_W + $clog2(mavg_pkg::MAX_WINDOW)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_valid,
  output logic                    job_ready,
  input  logic signed [SUM_W-1:0] job_sum,
  input  logic [CW-1:0]           job_held,
  output logic                    result_valid,
  input  logic                    result_ready,
  output mavg_pkg::result_t       result
);
  import mavg_pkg::*;

  localparam int CNTW = $clog2(SUM_W);

  div_state_t        state, state_next;
  logic [CW:0]       rem, rem_next;
  logic [SUM_W-1:0]  quo, quo_next;
  logic [CW-1:0]     held, held_next;
  logic              neg, neg_next;
  logic [CNTW-1:0]   cnt, cnt_next;
  logic              res_valid_next;
  result_t           res_next;

  logic [SUM_W-1:0]  mag;
  logic [CW:0]       trial;
  logic              ge;
  logic [SUM_W-1:0]  qsigned;
  logic              out_free;

  assign mag      = job_sum[SUM_W-1] ? (~job_sum + SUM_W'(1)) : job_sum;
  assign trial    = {rem[CW-1:0], quo[SUM_W-1]};
  assign ge       = (trial >= {1'b0, held});
  assign qsigned  = neg ? (~quo + SUM_W'(1)) : quo;
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= DS_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rem    <= rem_next;
    quo    <= quo_next;
    held   <= held_next;
    neg    <= neg_next;
    cnt    <= cnt_next;
    result <= res_next;
  end

  always_comb begin
    state_next     = state;
    rem_next       = rem;
    quo_next       = quo;
    held_next      = held;
    neg_next       = neg;
    cnt_next       = cnt;
    res_next       = result;
    res_valid_next = result_valid && !result_ready;
    job_ready      = 1'b0;
    case (state)
      DS_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          quo_next   = mag;
          rem_next   = '0;
          held_next  = job_held;
          neg_next   = job_sum[SUM_W-1];
          cnt_next   = CNTW'(SUM_W - 1);
          state_next = DS_RUN;
        end
      end
      DS_RUN: begin
        rem_next = ge ? (trial - {1'b0, held}) : trial;
        quo_next = {quo[SUM_W-2:0], ge};
        cnt_next = cnt - CNTW'(1);
        if (cnt == '0) begin
          state_next = DS_DONE;
        end
      end
      DS_DONE: begin
        if (out_free) begin
          res_next.average      = qsigned[SAMPLE_W-1:0];
          res_next.samples_held = HELD_W'(held);
          res_valid_next        = 1'b1;
          state_next            = DS_IDLE;
        end
      end
      default: begin
        state_next = DS_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/moving_average_filter_core.sv
// Top level of the boxcar moving average filter.
// Averages the last window_len signed samples (1..MAX_WINDOW, default 8) using a history
// ring and a running sum; until the window fills, the sum is divided by the samples seen.
// A push beat passes through the front end (history read, then sum update and
// write-back) and then the divider, which produces one quotient bit per cycle,
// SUM_W = 16 + clog2(MAX_WINDOW) bits in all. A two-entry queue lets the front end
// run ahead of the divider, so the divider sets the sustained push rate. A clear
// beat yields no result and keeps the front end idle. Writing the window length
// also clears the history; writes of 0 or above MAX_WINDOW select 8. No clearing
// pass follows reset.
module moving_average_filter_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [mavg_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  mavg_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output mavg_pkg::result_t           result
);
  import mavg_pkg::*;

  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int SW    = $clog2(MAX_WINDOW);
  localparam int SUM_W = SAMPLE_W + SW;
  localparam int JOB_W = SUM_W + CW;

  logic                    fj_valid, fj_ready;
  logic signed [SUM_W-1:0] fj_sum;
  logic [CW-1:0]           fj_held;
  logic                    bj_valid, bj_ready;
  logic [JOB_W-1:0]        bj_data;

  mavg_front #(
    .SW         (SW),
    .CW         (CW),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .job_valid  (fj_valid),
    .job_ready  (fj_ready),
    .job_sum    (fj_sum),
    .job_held   (fj_held)
  );

  mavg_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  ({fj_sum, fj_held}),
    .rd_valid (bj_valid),
    .rd_ready (bj_ready),
    .rd_data  (bj_data)
  );

  mavg_divider #(
    .CW         (CW),
    .SUM_W      (SUM_W)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (bj_valid),
    .job_ready    (bj_ready),
    .job_sum      (bj_data[JOB_W-1:CW]),
    .job_held     (bj_data[CW-1:0]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: hw/rtl/mavg_checker.sv
// Port-level assertions for the moving average filter, bound to the top level.
module mavg_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input mavg_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input mavg_pkg::result_t result
);
  import mavg_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.samples_held != '0)
                     && (32'(result.samples_held) <= MAX_WINDOW))
    else $error("samples_held out of range");

  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.action == ACT_PUSH) |=> !item_ready)
    else $error("front end ready in the cycle after a push beat");

endmodule

bind moving_average_filter_core mavg_checker u_mavg_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
